@@ rtl/core/lbur_pkg.sv @@
`default_nettype none
package lbur_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 5;

    localparam logic [DATA_W-1:0] LCG_MUL     = 32'd1664525;
    localparam logic [DATA_W-1:0] LCG_INC     = 32'd1013904223;
    localparam logic [DATA_W-1:0] BOUND_LIMIT = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] ERROR_VALUE = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] DRAW_SPAN   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] SEED_RESET  = 32'd1;

    typedef enum logic {
        DIV_BINS,
        DIV_DRAW
    } t_div_sel;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ERROR,
        SRC_QUOTIENT
    } t_src;

    typedef struct packed {
        logic     div_start;
        t_div_sel div_sel;
        logic     limit_load;
        logic     mul;
        logic     add;
        logic     out_load;
        t_src     out_src;
    } t_cmd;

    typedef struct packed {
        logic bound_zero;
        logic bound_over;
        logic div_done;
        logic reject;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/core/lbur_ifs.sv @@
`default_nettype none
interface lbur_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] upper_bound;

    modport source (output valid, output upper_bound, input ready);
    modport sink   (input valid, input upper_bound, output ready);
endinterface

interface lbur_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        range_error;

    modport source (output valid, output value, output range_error, input ready);
    modport sink   (input valid, input value, input range_error, output ready);
endinterface

interface lbur_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lbur_div.sv @@
`default_nettype none
module lbur_div
    import lbur_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [DATA_W-1:0]      o_quotient,
    output logic [DATA_W-1:0]      o_remainder
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_div;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted = {r_rem, r_quo[DATA_W-1]};
        diff    = shifted - {1'b0, r_div};
        fits    = shifted >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], fits};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

@@ rtl/core/lbur_dp.sv @@
`default_nettype none
module lbur_dp
    import lbur_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [DATA_W-1:0] i_cfg_seed,
    input  wire logic [DATA_W-1:0] i_upper_bound,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    output logic [DATA_W-1:0]      o_value,
    output logic                   o_range_error
);

    logic [DATA_W-1:0] r_state;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_limit;
    logic [DATA_W-1:0] r_bin_width;
    logic [DATA_W-1:0] r_value;
    logic              r_range_error;

    logic [DATA_W-1:0] div_dividend;
    logic [DATA_W-1:0] div_divisor;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;
    logic [DATA_W-1:0] div_remainder;
    logic [DATA_W-1:0] draw;
    logic [DATA_W-1:0] n_value;

    // upper 31 bits of the generator word
    assign draw = {1'b0, r_state[DATA_W-1:1]};

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_BINS: begin
                div_dividend = DRAW_SPAN;
                div_divisor  = i_upper_bound + 1'b1;
            end
            DIV_DRAW: begin
                div_dividend = draw;
                div_divisor  = r_bin_width;
            end
            default: begin
                div_dividend = draw;
                div_divisor  = r_bin_width;
            end
        endcase
    end

    lbur_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEED_RESET;
        end else if (i_cfg_we) begin
            r_state <= i_cfg_seed;
        end else if (i_cmd.add) begin
            r_state <= r_prod + LCG_INC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= r_state * LCG_MUL;
        end
        if (i_cmd.limit_load) begin
            r_bin_width <= div_quotient;
            r_limit     <= DRAW_SPAN - div_remainder;
        end
        if (i_cmd.out_load) begin
            r_value       <= n_value;
            r_range_error <= (i_cmd.out_src == SRC_ERROR);
        end
    end

    always_comb begin
        unique case (i_cmd.out_src)
            SRC_ZERO:     n_value = '0;
            SRC_ERROR:    n_value = ERROR_VALUE;
            SRC_QUOTIENT: n_value = div_quotient;
            default:      n_value = '0;
        endcase
    end

    always_comb begin
        o_sts.bound_zero = (i_upper_bound == '0);
        o_sts.bound_over = (i_upper_bound > BOUND_LIMIT);
        o_sts.div_done   = div_done;
        o_sts.reject     = (draw >= r_limit);
    end

    assign o_value       = r_value;
    assign o_range_error = r_range_error;

endmodule
`default_nettype wire

@@ rtl/core/lbur_ctrl.sv @@
`default_nettype none
module lbur_ctrl
    import lbur_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_BINS,
        S_MUL,
        S_ADD,
        S_CHECK,
        S_DIV_DRAW,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_src   r_src;
    t_src   n_src;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '{div_start: 1'b0, div_sel: DIV_BINS, limit_load: 1'b0,
                        mul: 1'b0, add: 1'b0, out_load: 1'b0, out_src: r_src};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_sts.bound_zero) begin
                        n_src   = SRC_ZERO;
                        n_state = S_DONE;
                    end else if (i_sts.bound_over) begin
                        n_src   = SRC_ERROR;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_src           = SRC_QUOTIENT;
                        n_state         = S_DIV_BINS;
                    end
                end
            end
            S_DIV_BINS: begin
                if (i_sts.div_done) begin
                    o_cmd.limit_load = 1'b1;
                    n_state          = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                // redraw until the word falls below the limit
                if (i_sts.reject) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_DRAW;
                    n_state         = S_DIV_DRAW;
                end
            end
            S_DIV_DRAW: begin
                o_cmd.div_sel = DIV_DRAW;
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_src       <= SRC_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_src       <= n_src;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ rtl/core/lcg_bounded_uniform_random.sv @@
// Channel   Dir  Payload                       Transaction
// i_req     in   upper_bound[31:0]             valid & ready at rising i_clk
// o_rsp     out  value[31:0], range_error      valid & ready at rising i_clk
// i_cfg     in   seed[31:0]                    valid & ready; ready is always high
//
// A zero or out-of-range bound skips the divider and loads o_rsp once it is free.
// Otherwise the steps are: the bin-size division, then per draw a multiply, an add
// and a check, repeated while the draw is rejected, then the final division, and
// last the load into o_rsp; the next request is taken once o_rsp has been loaded.
// Both divisions run on the one 32-step restoring divider.
// Reset (synchronous, active low) loads the generator with 1 and empties the
// output register. A new request is taken while a result waits in o_rsp.
`default_nettype none
module lcg_bounded_uniform_random
    import lbur_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lbur_req_if.sink   i_req,
    lbur_rsp_if.source o_rsp,
    lbur_cfg_if.sink   i_cfg
);

    t_cmd cmd;
    t_sts sts;
    logic cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    lbur_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lbur_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_seed    (i_cfg.seed),
        .i_upper_bound (i_req.upper_bound),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_value       (o_rsp.value),
        .o_range_error (o_rsp.range_error)
    );

endmodule
`default_nettype wire
